@@ rtl/core/clc_pkg.sv @@
// Shared types and constants for the CHS/LBA converter pipeline.
// No dependencies; imported by every module in rtl/core.
package clc_pkg;

    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 2'd1;

    localparam logic [5:0] SPT_RESET   = 6'd63;
    localparam logic [7:0] HEADS_RESET = 8'd255;

    localparam logic [9:0] CYL_INVALID = 10'd1023;

    localparam int REM_W = 24;
    localparam int QUO_W = 18;   // [17:8] cylinder, [7:0] head

    typedef enum logic
    {
        OP_CHS_TO_LBA = 1'b0,
        OP_LBA_TO_CHS = 1'b1
    } op_t;

    // One transaction as it travels through the divider stages
    typedef struct packed
    {
        op_t               op;
        logic              bad;       // CHS input invalid
        logic [24:0]       mac;       // spt * (head + heads * cyl)
        logic [5:0]        sec;       // CHS input sector
        logic              clamp;     // LBA cylinder saturates
        logic [13:0]       dvs;       // spt * heads
        logic [5:0]        spt;
        logic [7:0]        hds;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } pipe_t;

endpackage

@@ rtl/core/chs_lba_convert.sv @@
// CHS <-> LBA converter, fully pipelined: one transaction per clock, never busy.
// 12 register stages, most of them for the 10-bit cylinder and 8-bit head restoring
// division, two bits/stage.
// Reset clears all valid bits and loads geometry 63 sectors / 255 heads.
// Results are presented for one cycle only; the receiver cannot stall.
// Depends on clc_pkg, clc_front, clc_div_stage, clc_pack.
module chs_lba_convert
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [23:0]                    chs_in,
    input  logic [31:0]                    lba_in,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [clc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           done,
    output logic [31:0]                    lba_out,
    output logic [23:0]                    chs_out,
    output logic                           chs_invalid,
    output logic                           chs_clamped
);
    import clc_pkg::*;

    localparam int NSTAGE = 9;

    logic [5:0] spt_reg;
    logic [7:0] hds_reg;

    logic  stg_valid [0:NSTAGE];
    pipe_t stg_pipe  [0:NSTAGE];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg <= SPT_RESET;
            hds_reg <= HEADS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SPT:   spt_reg <= cfg_data[5:0];
                CFG_HEADS: hds_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    clc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .operation (operation),
        .chs_in    (chs_in),
        .lba_in    (lba_in),
        .spt       (spt_reg),
        .hds       (hds_reg),
        .out_valid (stg_valid[0]),
        .out_pipe  (stg_pipe[0])
    );

    // Stages 0..4: cylinder bits 9..0; stages 5..8: head bits 7..0
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_div
        clc_div_stage
        #(
            .IS_HEAD (k >= 5),
            .BIT_HI  ((k < 5) ? (9 - 2 * k) : (7 - 2 * (k - 5)))
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_pipe   (stg_pipe[k]),
            .out_valid (stg_valid[k + 1]),
            .out_pipe  (stg_pipe[k + 1])
        );
    end

    clc_pack u_pack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stg_valid[NSTAGE]),
        .in_pipe     (stg_pipe[NSTAGE]),
        .done        (done),
        .lba_out     (lba_out),
        .chs_out     (chs_out),
        .chs_invalid (chs_invalid),
        .chs_clamped (chs_clamped)
    );

    // Every accepted transaction comes out as a done strobe at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##12 done)
        else $error("result strobe missing after pipeline latency");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && chs_invalid |-> lba_out == 32'd0 && !chs_clamped)
        else $error("invalid CHS produced nonzero LBA");

    a_clamp_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && chs_clamped |-> chs_out[15:14] == 2'b11 && chs_out[23:16] == 8'hFF
                                && lba_out == 32'd0 && !chs_invalid)
        else $error("clamped CHS not saturated to cylinder 1023");

    // An unclamped LBA conversion always yields sector 1 or more
    a_sector_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !chs_clamped && chs_out != 24'd0 |-> chs_out[13:8] != 6'd0)
        else $error("LBA conversion produced sector zero");

endmodule

@@ rtl/core/clc_front.sv @@
// Front end: field decode, geometry products, clamp test, CHS multiply-add.
// Two register stages. Depends on clc_pkg.
module clc_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           operation,
    input  logic [23:0]    chs_in,
    input  logic [31:0]    lba_in,
    input  logic [5:0]     spt,
    input  logic [7:0]     hds,
    output logic           out_valid,
    output clc_pkg::pipe_t out_pipe
);
    import clc_pkg::*;

    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [31:0] s1_lba_reg;
    logic [7:0]  s1_head_reg;
    logic [5:0]  s1_sec_reg;
    logic        s1_bad_reg;
    logic [17:0] s1_prod_reg;
    logic [13:0] s1_dvs_reg;
    logic [5:0]  s1_spt_reg;
    logic [7:0]  s1_hds_reg;

    logic [9:0]  cyl_in;
    logic [5:0]  sec_in;
    logic [18:0] hsum;
    logic        s2_valid_reg;
    pipe_t       s2_pipe_reg;
    pipe_t       s2_pipe_next;

    assign cyl_in = {chs_in[15:14], chs_in[23:16]};
    assign sec_in = chs_in[13:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= op_t'(operation);
        s1_lba_reg  <= lba_in;
        s1_head_reg <= chs_in[7:0];
        s1_sec_reg  <= sec_in;
        s1_bad_reg  <= (cyl_in == CYL_INVALID) || (sec_in == 6'd0);
        s1_prod_reg <= {10'd0, hds} * {8'd0, cyl_in};
        s1_dvs_reg  <= {8'd0, spt} * {6'd0, hds};
        s1_spt_reg  <= spt;
        s1_hds_reg  <= hds;
        s2_pipe_reg <= s2_pipe_next;
    end

    assign hsum = {1'b0, s1_prod_reg} + {11'd0, s1_head_reg};

    always_comb
    begin
        s2_pipe_next       = '0;
        s2_pipe_next.op    = s1_op_reg;
        s2_pipe_next.bad   = s1_bad_reg;
        s2_pipe_next.mac   = {6'd0, hsum} * {19'd0, s1_spt_reg};
        s2_pipe_next.sec   = s1_sec_reg;
        // cylinder >= 1024 exactly when lba / 1024 >= spt * heads
        s2_pipe_next.clamp = (s1_dvs_reg == 14'd0)
                          || (s1_lba_reg[31:10] >= {8'd0, s1_dvs_reg});
        s2_pipe_next.dvs   = s1_dvs_reg;
        s2_pipe_next.spt   = s1_spt_reg;
        s2_pipe_next.hds   = s1_hds_reg;
        s2_pipe_next.rem   = s1_lba_reg[REM_W-1:0];
        s2_pipe_next.quo   = '0;
    end

    assign out_valid = s2_valid_reg;
    assign out_pipe  = s2_pipe_reg;

endmodule

@@ rtl/core/clc_div_stage.sv @@
// One restoring-division stage: two quotient bits per clock.
// Cylinder phase divides by spt*heads, head phase by spt. Depends on clc_pkg.
module clc_div_stage
#(
    parameter bit IS_HEAD = 1'b0,
    parameter int BIT_HI  = 9
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  clc_pkg::pipe_t in_pipe,
    output logic           out_valid,
    output clc_pkg::pipe_t out_pipe
);
    import clc_pkg::*;

    localparam int QHI = IS_HEAD ? BIT_HI : BIT_HI + 8;

    logic             valid_reg;
    pipe_t            pipe_reg;
    pipe_t            pipe_next;
    logic [REM_W-1:0] dvr;
    logic [REM_W-1:0] sh_hi;
    logic [REM_W-1:0] sh_lo;

    assign dvr   = IS_HEAD ? {18'd0, in_pipe.spt} : {10'd0, in_pipe.dvs};
    assign sh_hi = dvr << BIT_HI;
    assign sh_lo = dvr << (BIT_HI - 1);

    always_comb
    begin
        pipe_next = in_pipe;
        if (pipe_next.rem >= sh_hi)
        begin
            pipe_next.rem      = pipe_next.rem - sh_hi;
            pipe_next.quo[QHI] = 1'b1;
        end
        if (pipe_next.rem >= sh_lo)
        begin
            pipe_next.rem          = pipe_next.rem - sh_lo;
            pipe_next.quo[QHI - 1] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

@@ rtl/core/clc_pack.sv @@
// Output stage: final LBA add, CHS saturation and packing, result registers.
// Depends on clc_pkg.
module clc_pack
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  clc_pkg::pipe_t in_pipe,
    output logic           done,
    output logic [31:0]    lba_out,
    output logic [23:0]    chs_out,
    output logic           chs_invalid,
    output logic           chs_clamped
);
    import clc_pkg::*;

    logic        done_reg;
    logic [31:0] lba_reg;
    logic [23:0] chs_reg;
    logic        invalid_reg;
    logic        clamped_reg;

    logic [31:0] lba_next;
    logic [23:0] chs_next;
    logic        invalid_next;
    logic        clamped_next;
    logic [9:0]  cyl;
    logic [7:0]  head;
    logic [5:0]  sec;

    always_comb
    begin
        if (in_pipe.clamp)
        begin
            cyl  = CYL_INVALID;
            head = in_pipe.hds - 8'd1;
            sec  = in_pipe.spt;
        end
        else
        begin
            cyl  = in_pipe.quo[17:8];
            head = in_pipe.quo[7:0];
            sec  = in_pipe.rem[5:0] + 6'd1;
        end

        lba_next     = '0;
        chs_next     = '0;
        invalid_next = 1'b0;
        clamped_next = 1'b0;
        case (in_pipe.op)
            OP_CHS_TO_LBA:
            begin
                invalid_next = in_pipe.bad;
                if (!in_pipe.bad)
                    lba_next = {7'd0, in_pipe.mac} + {26'd0, in_pipe.sec} - 32'd1;
            end
            OP_LBA_TO_CHS:
            begin
                clamped_next = in_pipe.clamp;
                chs_next     = {cyl[7:0], cyl[9:8], sec, head};
            end
            default:
            begin
                lba_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        lba_reg     <= lba_next;
        chs_reg     <= chs_next;
        invalid_reg <= invalid_next;
        clamped_reg <= clamped_next;
    end

    assign done        = done_reg;
    assign lba_out     = lba_reg;
    assign chs_out     = chs_reg;
    assign chs_invalid = invalid_reg;
    assign chs_clamped = clamped_reg;

endmodule

@@ tb/sv/tb_chs_lba_convert.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chs_lba_convert: directed and random CHS/LBA conversions
// checked against a local geometry model. Depends on clc_pkg and the chs_lba_convert RTL.
module tb_chs_lba_convert;
    import clc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES = 24;   // pipeline is 12 deep

    typedef struct packed
    {
        logic [31:0] lba;
        logic [23:0] chs;
        logic        invalid;
        logic        clamped;
    } conv_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 operation;
    logic [23:0]          chs_in;
    logic [31:0]          lba_in;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 done;
    logic [31:0]          lba_out;
    logic [23:0]          chs_out;
    logic                 chs_invalid;
    logic                 chs_clamped;

    // Local copy of the geometry registers
    logic [5:0] geo_spt;
    logic [7:0] geo_heads;

    conv_result_t pending_conversions[$];
    int mismatches;
    int conversions_sent;
    int results_checked;
    int geometry_writes;

    chs_lba_convert u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .chs_in      (chs_in),
        .lba_in      (lba_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .lba_out     (lba_out),
        .chs_out     (chs_out),
        .chs_invalid (chs_invalid),
        .chs_clamped (chs_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic conv_result_t convert_sector_address(op_t op, logic [23:0] chs,
                                                            logic [31:0] lba);
        logic [31:0]  spt;
        logic [31:0]  hds;
        logic [31:0]  head;
        logic [31:0]  sec;
        logic [31:0]  cyl;
        logic [31:0]  rem;
        logic         clamp;
        conv_result_t r;
        r   = '0;
        spt = {26'd0, geo_spt};
        hds = {24'd0, geo_heads};
        if (op == OP_CHS_TO_LBA)
        begin
            head = {24'd0, chs[7:0]};
            sec  = {26'd0, chs[13:8]};
            cyl  = {22'd0, chs[15:14], chs[23:16]};
            r.invalid = (cyl == {22'd0, CYL_INVALID}) || (sec == 0);
            if (!r.invalid)
                r.lba = sec + spt * (head + hds * cyl) - 1;
        end
        else
        begin
            // zero geometry behaves like a divider returning all ones
            if (spt == 0 || hds == 0)
            begin
                clamp = 1'b1;
                cyl   = 0;
            end
            else
            begin
                cyl   = (lba / spt) / hds;
                clamp = (cyl >= 1024);
            end
            if (clamp)
            begin
                cyl  = {22'd0, CYL_INVALID};
                head = (hds - 1) & 32'hFF;
                sec  = spt & 32'h3F;
            end
            else
            begin
                rem  = lba - cyl * spt * hds;
                head = rem / spt;
                sec  = rem - head * spt + 1;
            end
            r.chs     = {cyl[7:0], sec[7:0] | {cyl[9:8], 6'd0}, head[7:0]};
            r.clamped = clamp;
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_conversions.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_geometry_reg(logic [CFG_IDX_W-1:0] index, logic [7:0] data);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (index == CFG_SPT)
            geo_spt = data[5:0];
        else if (index == CFG_HEADS)
            geo_heads = data;
        geometry_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = 8'($urandom());
    endtask

    task automatic set_geometry(logic [7:0] spt_data, logic [7:0] heads_data);
        write_geometry_reg(CFG_SPT, spt_data);
        write_geometry_reg(CFG_HEADS, heads_data);
    endtask

    // One conversion transaction; idle_pct is the percentage of cycles the sender sits idle
    task automatic send_conversion(op_t op, logic [23:0] chs, logic [31:0] lba, int idle_pct);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start     = 1'b0;
            operation = 1'($urandom());
            chs_in    = 24'($urandom());
            lba_in    = $urandom();
            @(negedge clk);
        end
        start     = 1'b1;
        operation = op;
        chs_in    = chs;
        lba_in    = lba;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_conversions.push_back(convert_sector_address(op, chs, lba));
        conversions_sent++;
    endtask

    task automatic release_start();
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic run_random_items(int count, int idle_pct);
        op_t         op;
        logic [23:0] chs;
        logic [31:0] lba;
        logic [9:0]  cyl;
        logic [5:0]  sec;
        logic [7:0]  head;
        int unsigned span;
        int          sel;
        for (int i = 0; i < count; i++)
        begin
            op   = op_t'($urandom_range(0, 1));
            span = 1024 * geo_spt * geo_heads;
            cyl  = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 1) != 0 && geo_spt != 0)
                sec = 6'($urandom_range(1, geo_spt));
            else
                sec = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 1) != 0 && geo_heads != 0)
                head = 8'($urandom_range(0, geo_heads - 1));
            else
                head = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                chs = 24'($urandom());
            else
                chs = {cyl[7:0], cyl[9:8], sec, head};
            sel = $urandom_range(0, 99);
            if (span == 0 || sel >= 75)
                lba = $urandom();
            else if (sel < 55)
                lba = $urandom_range(0, span - 1);
            else
                lba = span + $urandom_range(0, 128) - 64;   // around the clamp boundary
            send_conversion(op, chs, lba, idle_pct);
        end
        release_start();
    endtask

    task automatic test_chs_to_lba_extremes();
        send_conversion(OP_CHS_TO_LBA, 24'h000000, 32'h0, 0);          // sector zero
        send_conversion(OP_CHS_TO_LBA, 24'h000100, 32'hFFFFFFFF, 0);   // first sector
        send_conversion(OP_CHS_TO_LBA, 24'hFEFFFF, 32'h0, 0);          // last valid
        send_conversion(OP_CHS_TO_LBA, 24'hFFC100, 32'h0, 0);          // cylinder 1023
        send_conversion(OP_CHS_TO_LBA, 24'hFFFFFF, 32'h0, 0);
        send_conversion(OP_CHS_TO_LBA, 24'h00C0FF, 32'h0, 0);
        send_conversion(OP_CHS_TO_LBA, 24'h013F00, 32'h0, 0);
        release_start();
    endtask

    task automatic test_lba_to_chs_extremes();
        send_conversion(OP_LBA_TO_CHS, 24'hFFFFFF, 32'd0, 0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd1, 0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd62, 0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd63, 0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd16064, 0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd16450559, 0);        // last unclamped
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd16450560, 0);        // first clamped
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'h80000000, 0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'hFFFFFFFF, 0);
        release_start();
    endtask

    task automatic test_zero_geometry();
        set_geometry(8'h40, 8'd255);    // upper data bits dropped: spt reads as 0
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd12345, 0);
        send_conversion(OP_CHS_TO_LBA, 24'h020305, 32'h0, 0);
        release_start();
        set_geometry(8'd63, 8'd0);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd12345, 0);
        send_conversion(OP_CHS_TO_LBA, 24'h020305, 32'h0, 0);
        release_start();
        set_geometry(8'hFF, 8'd255);
    endtask

    task automatic test_spare_register_index();
        write_geometry_reg(CFG_SPARE_A, 8'h05);
        write_geometry_reg(CFG_SPARE_B, 8'hAA);
        send_conversion(OP_LBA_TO_CHS, 24'h0, 32'd16450559, 0);
        send_conversion(OP_CHS_TO_LBA, 24'hFEFFFF, 32'h0, 0);
        release_start();
    endtask

    task automatic test_geometry_extremes();
        set_geometry(8'd1, 8'd1);
        run_random_items(60, 0);
        set_geometry(8'd1, 8'd255);
        run_random_items(60, 0);
        set_geometry(8'hC1 | 8'd62, 8'd1);
        run_random_items(60, 0);
        set_geometry(8'hBF, 8'd255);
        run_random_items(60, 0);
    endtask

    task automatic test_random_traffic(int idle_pct);
        for (int g = 0; g < 4; g++)
        begin
            set_geometry({2'($urandom_range(0, 3)), 6'($urandom_range(1, 63))},
                         8'($urandom_range(1, 255)));
            run_random_items(150, idle_pct);
        end
    endtask

    always @(posedge clk)
    begin
        conv_result_t e;
        if (rst_n && done === 1'b1)
        begin
            if (pending_conversions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: lba=%h chs=%h inv=%b clamp=%b",
                             $realtime, lba_out, chs_out, chs_invalid, chs_clamped);
            end
            else
            begin
                e = pending_conversions.pop_front();
                results_checked++;
                if (lba_out !== e.lba || chs_out !== e.chs
                    || chs_invalid !== e.invalid || chs_clamped !== e.clamped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] mismatch: exp lba=%h chs=%h inv=%b clamp=%b,",
                                 $realtime, e.lba, e.chs, e.invalid, e.clamped);
                        $display("    got lba=%h chs=%h inv=%b clamp=%b",
                                 lba_out, chs_out, chs_invalid, chs_clamped);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        operation        = OP_CHS_TO_LBA;
        chs_in           = '0;
        lba_in           = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_SPT;
        cfg_data         = '0;
        geo_spt          = SPT_RESET;
        geo_heads        = HEADS_RESET;
        mismatches       = 0;
        conversions_sent = 0;
        results_checked  = 0;
        geometry_writes  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_chs_to_lba_extremes();
        test_lba_to_chs_extremes();
        test_spare_register_index();
        test_zero_geometry();
        test_geometry_extremes();
        test_random_traffic(0);
        test_random_traffic(78);
        test_random_traffic(14);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d conversions, checked %0d results, %0d register writes;",
                 conversions_sent, results_checked, geometry_writes);
        $display("geometries from 1x1 to 63x255 incl. zero, sender idle 0/14/78 percent.");
        if (mismatches == 0 && pending_conversions.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
